@@ rtl/core/rcpf_pkg.sv @@
// ============================================================================
// rcpf_pkg
// Shared types and constants for the robot command packet framer.
// ============================================================================
`default_nettype none

package rcpf_pkg;

    localparam int ROBOT_SLOTS = 16;
    localparam int SLOT_W      = (ROBOT_SLOTS > 1) ? $clog2(ROBOT_SLOTS) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PKT_LEN     = 26;

    localparam int VEL_MAX     = 511;
    localparam int SPIN_MAX    = 2047;
    localparam int RECIP10     = 6554;     // 2^16 / 10, rounded up
    localparam int SPIN_SCALE  = 160;
    localparam int KICK_DEAD   = 5;
    localparam int POWER_MIN   = 10;
    localparam int POWER_MAX   = 127;
    localparam int DRIBBLE_ON  = 128;

    localparam logic [7:0] PKT_HEAD = 8'h40;
    localparam logic [7:0] PKT_EOL  = 8'h0a;

    typedef struct packed {
        logic        report;
        logic        chip;
        logic        usedir;
        logic        dribble;    // level 3 when set
        logic [6:0]  power;
        logic        sx;
        logic        sy;
        logic        sr;
        logic [8:0]  mx;
        logic [8:0]  my;
        logic [10:0] mr;
    } t_slot;

    typedef struct packed {
        logic [3:0] bot_idx;
        logic       id_ok;
        logic       frame_end;
        t_slot      cmd;
    } t_qitem;

    typedef logic [PKT_LEN-1:0][7:0] t_pkt;

endpackage

`default_nettype wire

@@ rtl/core/robot_command_packet_framer.sv @@
// ============================================================================
// robot_command_packet_framer
// Per-robot command table with frame-end packing into 26-byte radio packets.
// ============================================================================
// A command is taken whenever start is high and busy is low, one per clock;
// it is converted and put in a 4-entry queue, and the back end stores it in
// its robot slot as it leaves the queue. A command with frame_end set starts
// a walk over the slot table, one slot per clock, that ends at the last
// valid slot; the back end takes nothing from the queue during the walk.
// Packets of up to four robots come out as one-cycle o_strobe pulses, each
// in the cycle after the walk step that closes it, with o_last_packet on the
// final one. The receiver has no way to stall; busy rises only when the
// queue fills behind a walk.
`default_nettype none

module robot_command_packet_framer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         i_bot_idx,
    input  wire logic signed [13:0] i_vel_x,
    input  wire logic signed [13:0] i_vel_y,
    input  wire logic signed [12:0] i_spin_rate_q8,
    input  wire logic signed [9:0]  i_dribble_q8,
    input  wire logic [11:0]        i_kick_power,
    input  wire logic               i_chip_kick,
    input  wire logic               i_use_direction,
    input  wire logic               i_want_report,
    input  wire logic               i_frame_end,
    output logic                    o_strobe,
    output logic [63:0]             o_bytes_lo,
    output logic [63:0]             o_bytes_mid,
    output logic [63:0]             o_bytes_hi,
    output logic [15:0]             o_bytes_tail,
    output logic                    o_last_packet
);
    import rcpf_pkg::*;

    t_qitem item;
    t_qitem head;
    t_pkt   pkt;
    logic   full;
    logic   empty;
    logic   push;
    logic   pop;

    assign busy = full;
    assign push = start && !full;

    rcpf_front u_front (
        .i_bot_idx       (i_bot_idx),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_spin_rate_q8  (i_spin_rate_q8),
        .i_dribble_q8    (i_dribble_q8),
        .i_kick_power    (i_kick_power),
        .i_chip_kick     (i_chip_kick),
        .i_use_direction (i_use_direction),
        .i_want_report   (i_want_report),
        .i_frame_end     (i_frame_end),
        .o_item          (item)
    );

    rcpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    rcpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_pkt    (pkt),
        .o_last   (o_last_packet)
    );

    assign o_bytes_lo   = pkt[7:0];
    assign o_bytes_mid  = pkt[15:8];
    assign o_bytes_hi   = pkt[23:16];
    assign o_bytes_tail = pkt[25:24];

endmodule

`default_nettype wire

@@ rtl/core/rcpf_front.sv @@
// ============================================================================
// rcpf_front
// Converts one robot command into its packed radio fields.
// ============================================================================
`default_nettype none

module rcpf_front (
    input  wire logic [3:0]         i_bot_idx,
    input  wire logic signed [13:0] i_vel_x,
    input  wire logic signed [13:0] i_vel_y,
    input  wire logic signed [12:0] i_spin_rate_q8,
    input  wire logic signed [9:0]  i_dribble_q8,
    input  wire logic [11:0]        i_kick_power,
    input  wire logic               i_chip_kick,
    input  wire logic               i_use_direction,
    input  wire logic               i_want_report,
    input  wire logic               i_frame_end,
    output rcpf_pkg::t_qitem        o_item
);
    import rcpf_pkg::*;

    // returns {sign, magnitude}; |v|/10 via reciprocal, exact for |v| < 16384
    function automatic logic [9:0] f_vel(input logic signed [13:0] v);
        logic [13:0] a;
        logic [26:0] p;
        logic [10:0] q;
        logic [8:0]  m;
        a = v[13] ? 14'(-v) : 14'(v);
        p = {13'd0, a} * 27'(RECIP10);
        q = p[26:16];
        m = (q > 11'(VEL_MAX)) ? 9'(VEL_MAX) : q[8:0];
        return {v[13] && (q != 11'd0), m};
    endfunction

    logic [9:0]  vx;
    logic [9:0]  vy;
    logic [12:0] spin_abs;
    logic [20:0] spin_prod;
    logic [12:0] spin_q;
    logic [24:0] kick_prod;
    logic [8:0]  kick_q;
    logic [6:0]  power;

    always_comb begin
        vx        = f_vel(i_vel_x);
        vy        = f_vel(i_vel_y);
        spin_abs  = i_spin_rate_q8[12] ? 13'(-i_spin_rate_q8) : 13'(i_spin_rate_q8);
        spin_prod = {8'd0, spin_abs} * 21'(SPIN_SCALE);
        spin_q    = spin_prod[20:8];
        kick_prod = {13'd0, i_kick_power} * 25'(RECIP10);
        kick_q    = kick_prod[24:16];

        priority if (i_kick_power <= 12'(KICK_DEAD)) begin
            power = 7'd0;
        end else if (kick_q < 9'(POWER_MIN)) begin
            power = 7'(POWER_MIN);
        end else if (kick_q > 9'(POWER_MAX)) begin
            power = 7'(POWER_MAX);
        end else begin
            power = kick_q[6:0];
        end

        o_item.bot_idx     = i_bot_idx;
        o_item.id_ok       = ({1'b0, i_bot_idx} < 5'(ROBOT_SLOTS));
        o_item.frame_end   = i_frame_end;
        o_item.cmd.report  = i_want_report;
        o_item.cmd.chip    = i_chip_kick;
        o_item.cmd.usedir  = i_use_direction;
        o_item.cmd.dribble = (i_dribble_q8 > 10'sd128);
        o_item.cmd.power   = power;
        o_item.cmd.sx      = vx[9];
        o_item.cmd.mx      = vx[8:0];
        o_item.cmd.sy      = vy[9];
        o_item.cmd.my      = vy[8:0];
        o_item.cmd.sr      = i_spin_rate_q8[12] && (spin_q != 13'd0);
        o_item.cmd.mr      = (spin_q > 13'(SPIN_MAX)) ? 11'(SPIN_MAX) : spin_q[10:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/rcpf_queue.sv @@
// ============================================================================
// rcpf_queue
// Small FIFO of converted commands between front and back.
// ============================================================================
`default_nettype none

module rcpf_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire rcpf_pkg::t_qitem i_item,
    input  wire logic             i_pop,
    output rcpf_pkg::t_qitem      o_head,
    output logic                  o_full,
    output logic                  o_empty
);
    import rcpf_pkg::*;

    t_qitem            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rcpf_back.sv @@
// ============================================================================
// rcpf_back
// Stores commands in the slot table and packs the frame into packets.
// ============================================================================
`default_nettype none

module rcpf_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire rcpf_pkg::t_qitem i_head,
    output logic                  o_pop,
    output logic                  o_strobe,
    output rcpf_pkg::t_pkt        o_pkt,
    output logic                  o_last
);
    import rcpf_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} t_state;

    t_state                 r_state;
    logic [ROBOT_SLOTS-1:0] r_valid;
    t_slot                  r_slot [ROBOT_SLOTS];
    logic [SLOT_W-1:0]      r_idx;
    logic [1:0]             r_pos;
    t_pkt                   r_acc;
    t_pkt                   r_out;
    logic                   r_strobe;
    logic                   r_last;

    t_slot cur;
    logic  cur_valid;
    logic  rest;
    logic  emit;
    t_pkt  base;
    t_pkt  merged;

    always_comb begin
        cur       = r_slot[r_idx];
        cur_valid = r_valid[r_idx];

        // any valid slot above the current one
        rest = 1'b0;
        for (int k = 0; k < ROBOT_SLOTS; k++) begin
            if (SLOT_W'(k) > r_idx) begin
                rest = rest | r_valid[k];
            end
        end

        base     = '0;
        base[0]  = PKT_HEAD;
        base[25] = PKT_EOL;

        merged = r_acc;
        if (cur_valid) begin
            merged[0] = r_acc[0] | (8'h08 >> r_pos);
            for (int k = 0; k < 4; k++) begin
                if (r_pos == 2'(k)) begin
                    merged[4*k+1] = {cur.report, cur.chip, {2{cur.dribble}}, 4'(r_idx)};
                    merged[4*k+2] = {cur.sx, cur.mx[6:0]};
                    merged[4*k+3] = {cur.sy, cur.my[6:0]};
                    merged[4*k+4] = {cur.sr, cur.mr[6:0]};
                    merged[17+k]  = {cur.mx[8:7], cur.my[8:7], cur.mr[10:7]};
                    merged[21+k]  = {cur.usedir, cur.power};
                end
            end
        end

        // empty frame still sends one header-only packet
        emit = (r_state == S_WALK) &&
               ((cur_valid && (r_pos == 2'd3 || !rest)) || (r_valid == '0));
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_strobe = r_strobe;
    assign o_pkt    = r_out;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_head.id_ok) begin
                            r_valid[i_head.bot_idx[SLOT_W-1:0]] <= 1'b1;
                        end
                        if (i_head.frame_end) begin
                            r_state <= S_WALK;
                            r_idx   <= '0;
                            r_pos   <= '0;
                            r_acc   <= base;
                        end
                    end
                end
                S_WALK: begin
                    r_idx <= r_idx + 1'b1;
                    if (emit) begin
                        r_strobe <= 1'b1;
                        r_out    <= merged;
                        r_last   <= !rest;
                        r_acc    <= base;
                        r_pos    <= '0;
                        if (!rest) begin
                            r_state <= S_IDLE;
                            r_valid <= '0;
                        end
                    end else begin
                        r_acc <= merged;
                        if (cur_valid) begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.id_ok) begin
            r_slot[i_head.bot_idx[SLOT_W-1:0]] <= i_head.cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rcpf_checker.sv @@
// ============================================================================
// rcpf_checker
// Port-level checks on the packet output of the framer.
// ============================================================================
`default_nettype none

module rcpf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_strobe,
    input wire logic [63:0] o_bytes_lo,
    input wire logic [15:0] o_bytes_tail,
    input wire logic        o_last_packet
);

    // header nibble and line terminator on every packet
    a_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bytes_lo[7:4] == 4'h4) && (o_bytes_tail[15:8] == 8'h0a))
        else $error("packet framing bytes wrong");

    // robots fill positions from the first one on
    a_positions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bytes_lo[3:0] == 4'h0) || (o_bytes_lo[3:0] == 4'h8) ||
                     (o_bytes_lo[3:0] == 4'hc) || (o_bytes_lo[3:0] == 4'he) ||
                     (o_bytes_lo[3:0] == 4'hf))
        else $error("robot position bits not contiguous");

    // only the final packet of a frame may be partly filled
    a_full_unless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_packet) |-> (o_bytes_lo[3:0] == 4'hf))
        else $error("partial packet before end of frame");

    // the last packet of a frame is never followed at once by another, as a new frame must be dequeued first
    a_frame_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_packet) |=> !o_strobe)
        else $error("packet right after end of frame");

endmodule

bind robot_command_packet_framer rcpf_checker u_rcpf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_strobe      (o_strobe),
    .o_bytes_lo    (o_bytes_lo),
    .o_bytes_tail  (o_bytes_tail),
    .o_last_packet (o_last_packet)
);

`default_nettype wire

@@ bench/robot_command_packet_framer_tb.sv @@
// ============================================================================
// robot_command_packet_framer_tb
// Self-checking bench for the framer. Commands go in through start/busy and
// fill a predicted slot table. Each frame end expands into the packets it
// should produce. Every strobed packet is compared with the oldest one due.
// ============================================================================
`timescale 1ns / 1ps

import rcpf_pkg::*;

typedef struct packed {
    logic [3:0]  id;
    logic [13:0] vx;
    logic [13:0] vy;
    logic [12:0] spin;
    logic [9:0]  drib;
    logic [11:0] kick;
    logic        chip;
    logic        usedir;
    logic        report;
    logic        frame_end;
} t_robot_cmd;

typedef struct packed {
    bit        sx, sy, sr;
    bit [8:0]  mx, my;
    bit [10:0] mr;
    bit [1:0]  dribble;
    bit [6:0]  power;
    bit        chip, usedir, report;
} t_stored_cmd;

typedef struct packed {
    logic [63:0] lo;
    logic [63:0] mid;
    logic [63:0] hi;
    logic [15:0] tail;
    logic        last;
} t_radio_pkt;

class robot_table_packer;
    t_stored_cmd slot_cmd [ROBOT_SLOTS];
    bit          slot_used [ROBOT_SLOTS];
    int          walk_ids [ROBOT_SLOTS];
    t_radio_pkt  due_packets [$];
    int          mismatch_count;

    function new();
        foreach (slot_used[i]) slot_used[i] = 0;
        mismatch_count = 0;
    endfunction

    // divide by ten toward zero, sign only when the quotient is nonzero
    function void cvt_vel(input logic [13:0] raw, output bit s, output bit [8:0] m);
        int v;
        int q;
        v = $signed(raw);
        q = (v < 0 ? -v : v) / 10;
        s = (v < 0) && (q != 0);
        m = 9'(q > VEL_MAX ? VEL_MAX : q);
    endfunction

    function t_radio_pkt pack_packet(int pos, int n, bit last);
        logic [7:0]  b [PKT_LEN];
        t_radio_pkt  p;
        t_stored_cmd s;
        int          id;
        foreach (b[i]) b[i] = 8'h00;
        b[0] = PKT_HEAD;
        b[PKT_LEN-1] = PKT_EOL;
        for (int k = 0; k < n; k++) begin
            id = walk_ids[pos+k];
            s = slot_cmd[id];
            b[0] = b[0] | (8'h08 >> k);
            b[4*k+1] = {s.report, s.chip, s.dribble, 4'(id)};
            b[4*k+2] = {s.sx, s.mx[6:0]};
            b[4*k+3] = {s.sy, s.my[6:0]};
            b[4*k+4] = {s.sr, s.mr[6:0]};
            b[17+k]  = {s.mx[8:7], s.my[8:7], s.mr[10:7]};
            b[21+k]  = {s.usedir, s.power};
        end
        for (int i = 0; i < 8; i++) begin
            p.lo[8*i +: 8]  = b[i];
            p.mid[8*i +: 8] = b[8+i];
            p.hi[8*i +: 8]  = b[16+i];
        end
        p.tail = {b[25], b[24]};
        p.last = last;
        return p;
    endfunction

    function void take_command(t_robot_cmd c);
        t_stored_cmd s;
        int r, q, k;
        int nvalid, pos, npk, n;
        cvt_vel(c.vx, s.sx, s.mx);
        cvt_vel(c.vy, s.sy, s.my);
        r = $signed(c.spin);
        q = ((r < 0 ? -r : r) * SPIN_SCALE) / 256;
        s.sr = (r < 0) && (q != 0);
        s.mr = 11'(q > SPIN_MAX ? SPIN_MAX : q);
        r = $signed(c.drib);
        s.dribble = (r > DRIBBLE_ON) ? 2'd3 : 2'd0;
        k = c.kick;
        if (k <= KICK_DEAD) begin
            s.power = '0;
        end else begin
            q = k / 10;
            if (q < POWER_MIN) q = POWER_MIN;
            if (q > POWER_MAX) q = POWER_MAX;
            s.power = 7'(q);
        end
        s.chip = c.chip;
        s.usedir = c.usedir;
        s.report = c.report;
        // ids beyond the table are dropped, their frame end still counts
        if (int'(c.id) < ROBOT_SLOTS) begin
            slot_cmd[c.id] = s;
            slot_used[c.id] = 1;
        end
        if (!c.frame_end) return;

        nvalid = 0;
        for (int i = 0; i < ROBOT_SLOTS; i++) begin
            if (slot_used[i]) begin
                walk_ids[nvalid] = i;
                nvalid = nvalid + 1;
            end
        end
        pos = 0;
        npk = 0;
        do begin
            n = nvalid - pos;
            if (n > 4) n = 4;
            due_packets.push_back(pack_packet(pos, n, (pos + n) >= nvalid));
            pos = pos + n;
            npk = npk + 1;
        end while (pos < nvalid && npk < 4);
        foreach (slot_used[i]) slot_used[i] = 0;
    endfunction

    function void check_packet(t_radio_pkt got);
        t_radio_pkt exp;
        if (due_packets.size() == 0) begin
            mismatch_count++;
            $display("%0t: packet with none due: lo %h mid %h hi %h tail %h last %b",
                     $time, got.lo, got.mid, got.hi, got.tail, got.last);
            return;
        end
        exp = due_packets.pop_front();
        if (got.lo !== exp.lo) begin
            mismatch_count++;
            $display("%0t: bytes_lo expected %h actual %h", $time, exp.lo, got.lo);
        end
        if (got.mid !== exp.mid) begin
            mismatch_count++;
            $display("%0t: bytes_mid expected %h actual %h", $time, exp.mid, got.mid);
        end
        if (got.hi !== exp.hi) begin
            mismatch_count++;
            $display("%0t: bytes_hi expected %h actual %h", $time, exp.hi, got.hi);
        end
        if (got.tail !== exp.tail) begin
            mismatch_count++;
            $display("%0t: bytes_tail expected %h actual %h", $time, exp.tail, got.tail);
        end
        if (got.last !== exp.last) begin
            mismatch_count++;
            $display("%0t: last_packet expected %b actual %b", $time, exp.last, got.last);
        end
    endfunction

    function int pending();
        return due_packets.size();
    endfunction
endclass

module robot_command_packet_framer_tb;

    localparam int N_ITEMS     = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_bot_idx;
    logic [13:0] i_vel_x;
    logic [13:0] i_vel_y;
    logic [12:0] i_spin_rate_q8;
    logic [9:0]  i_dribble_q8;
    logic [11:0] i_kick_power;
    logic        i_chip_kick;
    logic        i_use_direction;
    logic        i_want_report;
    logic        i_frame_end;
    logic        o_strobe;
    logic [63:0] o_bytes_lo;
    logic [63:0] o_bytes_mid;
    logic [63:0] o_bytes_hi;
    logic [15:0] o_bytes_tail;
    logic        o_last_packet;

    robot_table_packer packer;
    t_robot_cmd        seen_cmd;
    t_radio_pkt        seen_pkt;
    int                sent;
    int                idle_pct;
    int                cycle_count;

    robot_command_packet_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_bot_idx       (i_bot_idx),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_spin_rate_q8  (i_spin_rate_q8),
        .i_dribble_q8    (i_dribble_q8),
        .i_kick_power    (i_kick_power),
        .i_chip_kick     (i_chip_kick),
        .i_use_direction (i_use_direction),
        .i_want_report   (i_want_report),
        .i_frame_end     (i_frame_end),
        .o_strobe        (o_strobe),
        .o_bytes_lo      (o_bytes_lo),
        .o_bytes_mid     (o_bytes_mid),
        .o_bytes_hi      (o_bytes_hi),
        .o_bytes_tail    (o_bytes_tail),
        .o_last_packet   (o_last_packet)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // inputs change only in the NBA region, so this sees the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                seen_pkt.lo   = o_bytes_lo;
                seen_pkt.mid  = o_bytes_mid;
                seen_pkt.hi   = o_bytes_hi;
                seen_pkt.tail = o_bytes_tail;
                seen_pkt.last = o_last_packet;
                packer.check_packet(seen_pkt);
            end
            if (start && !busy) begin
                seen_cmd.id        = i_bot_idx;
                seen_cmd.vx        = i_vel_x;
                seen_cmd.vy        = i_vel_y;
                seen_cmd.spin      = i_spin_rate_q8;
                seen_cmd.drib      = i_dribble_q8;
                seen_cmd.kick      = i_kick_power;
                seen_cmd.chip      = i_chip_kick;
                seen_cmd.usedir    = i_use_direction;
                seen_cmd.report    = i_want_report;
                seen_cmd.frame_end = i_frame_end;
                packer.take_command(seen_cmd);
            end
        end
    end

    function automatic t_robot_cmd make_cmd(int id, int vx, int vy, int spin, int drib,
                                            int kick, logic [3:0] flags);
        t_robot_cmd c;
        c.id   = 4'(id);
        c.vx   = 14'(vx);
        c.vy   = 14'(vy);
        c.spin = 13'(spin);
        c.drib = 10'(drib);
        c.kick = 12'(kick);
        {c.chip, c.usedir, c.report, c.frame_end} = flags;
        return c;
    endfunction

    // corners, values near zero, the nominal range, or any bit pattern
    function automatic int pick_signed(int w);
        int lim;
        lim = 1 << (w - 1);
        case ($urandom_range(7))
            0: return lim - 1;
            1: return -lim;
            2: return int'($urandom_range(0, 40)) - 20;
            3: return int'($urandom_range(0, lim + lim / 4)) - (lim / 2 + lim / 8);
            default: return int'($urandom_range(0, 2 * lim - 1)) - lim;
        endcase
    endfunction

    function automatic int pick_kick();
        case ($urandom_range(5))
            0: return $urandom_range(0, 12);
            1: return $urandom_range(95, 105);
            2: return $urandom_range(1265, 1285);
            3: return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic t_robot_cmd rand_cmd(int id, bit fe);
        int drib;
        drib = ($urandom_range(3) == 0) ? int'($urandom_range(124, 132)) : pick_signed(10);
        return make_cmd(id, pick_signed(14), pick_signed(14), pick_signed(13), drib,
                        pick_kick(), {3'($urandom), fe});
    endfunction

    task automatic send_cmd(input t_robot_cmd c);
        start           <= 1'b1;
        i_bot_idx       <= c.id;
        i_vel_x         <= c.vx;
        i_vel_y         <= c.vy;
        i_spin_rate_q8  <= c.spin;
        i_dribble_q8    <= c.drib;
        i_kick_power    <= c.kick;
        i_chip_kick     <= c.chip;
        i_use_direction <= c.usedir;
        i_want_report   <= c.report;
        i_frame_end     <= c.frame_end;
        do @(posedge i_clk); while (busy);
        sent++;
        idle_pct = (sent < N_ITEMS / 3) ? 11 : (sent < 2 * N_ITEMS / 3) ? 66 : 0;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin
        int flen;
        int span;
        int base;
        packer = new();
        sent = 0;
        idle_pct = 11;
        cycle_count = 0;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_bot_idx       <= '0;
        i_vel_x         <= '0;
        i_vel_y         <= '0;
        i_spin_rate_q8  <= '0;
        i_dribble_q8    <= '0;
        i_kick_power    <= '0;
        i_chip_kick     <= 1'b0;
        i_use_direction <= 1'b0;
        i_want_report   <= 1'b0;
        i_frame_end     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturation edges, truncation to zero, dribble and kick thresholds
        send_cmd(make_cmd(0, 8191, -8192, 4095, 129, 4095, 4'b1110));
        send_cmd(make_cmd(1, -9, -10, -1, 128, 5, 4'b0000));
        send_cmd(make_cmd(2, 5119, 5120, -4096, -512, 6, 4'b1000));
        send_cmd(make_cmd(3, -5120, -5119, 3276, 511, 1279, 4'b0100));
        send_cmd(make_cmd(4, 9, 10, 3277, -1, 1280, 4'b0010));
        // overwrite of slot 3, then frame end on the top slot
        send_cmd(make_cmd(3, -8191, 1, -410, 0, 99, 4'b1100));
        send_cmd(make_cmd(15, 0, 0, 0, 0, 0, 4'b0001));
        // one robot alone in a frame
        send_cmd(make_cmd(9, -1, 100, 409, 130, 100, 4'b0111));
        // full table written in descending order: four packets
        for (int k = 15; k >= 0; k--) send_cmd(rand_cmd(k, k == 0));

        while (sent < N_ITEMS) begin
            flen = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 24);
            case ($urandom_range(3))
                0: span = 3;
                1: span = 7;
                default: span = 15;
            endcase
            base = $urandom_range(0, 15 - span);
            for (int k = 0; k < flen; k++) begin
                send_cmd(rand_cmd(base + $urandom_range(0, span), k == flen - 1));
            end
        end

        start <= 1'b0;
        while (packer.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (packer.mismatch_count == 0 && packer.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
